FILE: sv/reb_pkg.sv
// Shared types, register indexes and the quadrature step table for the rotary encoder block.
`default_nettype none

package reb_pkg;

   // Event modes carried by every request transaction.
   typedef enum logic [1:0] {
      MODE_PIN        = 2'd0,
      MODE_BUTTON     = 2'd1,
      MODE_READ_DIR   = 2'd2,
      MODE_READ_PRESS = 2'd3
   } mode_type;

   // Register indexes of the control port.
   typedef enum logic [0:0] {
      CSR_DETENT_STEPS = 1'b0,
      CSR_DEBOUNCE_MS  = 1'b1
   } csr_index_type;

   localparam int DetentWidth   = 4;
   localparam int DebounceWidth = 16;
   localparam int TimeWidth     = 32;
   localparam int SumWidth      = 5;

   localparam logic [DetentWidth-1:0]   DETENT_RESET   = 4'd4;
   localparam logic [DebounceWidth-1:0] DEBOUNCE_RESET = 16'd250;

   typedef logic signed [1:0] dir_type;

   localparam dir_type DIR_NONE = 2'sb00;
   localparam dir_type DIR_CW   = 2'sb01;
   localparam dir_type DIR_CCW  = 2'sb11;

   // Step for each {previous A, previous B, new A, new B}.
   localparam dir_type QUAD_STEP [16] = '{
      DIR_NONE, DIR_CCW,  DIR_CW,   DIR_NONE,
      DIR_CW,   DIR_NONE, DIR_NONE, DIR_CCW,
      DIR_CCW,  DIR_NONE, DIR_NONE, DIR_CW,
      DIR_NONE, DIR_CW,   DIR_CCW,  DIR_NONE
   };

   // Control from the top level to the quadrature decoder.
   typedef struct packed {
      logic pin_evt;
      logic clr_dir;
   } quad_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/reb_if.sv
// Request and response channel interfaces of the rotary encoder block.
`default_nettype none

interface reb_req_if;
   logic              valid;
   logic              ready;
   reb_pkg::mode_type mode;
   logic              a_level;
   logic              b_level;
   logic              sw_level;
   logic [31:0]       now_ms;

   modport source (output valid, mode, a_level, b_level, sw_level, now_ms, input ready);
   modport sink   (input valid, mode, a_level, b_level, sw_level, now_ms, output ready);
endinterface

interface reb_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] direction;
   logic              pressed;

   modport source (output valid, direction, pressed, input ready);
   modport sink   (input valid, direction, pressed, output ready);
endinterface

`default_nettype wire

FILE: sv/reb_quad.sv
// Quadrature x4 decoder with detent accumulation and pending direction latch.
`default_nettype none

module reb_quad (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire logic [reb_pkg::DetentWidth-1:0]   detent,
   input  wire reb_pkg::quad_ctrl_type            ctrl,
   input  wire logic                              a_level,
   input  wire logic                              b_level,
   output reb_pkg::dir_type                       dir_upd
);
   import reb_pkg::*;

   logic [1:0]                 prev_ab_ff, prev_ab_in;
   logic signed [SumWidth-1:0] step_sum_ff, step_sum_in;
   dir_type                    dir_ff, dir_in;

   dir_type                    step;
   logic signed [SumWidth:0]   sum_ext;
   logic signed [SumWidth:0]   lim;
   logic signed [SumWidth:0]   neg_lim;

   always_comb begin
      step    = QUAD_STEP[{prev_ab_ff, a_level, b_level}];
      sum_ext = {step_sum_ff[SumWidth-1], step_sum_ff} + {{(SumWidth-1){step[1]}}, step};
      lim     = {{(SumWidth+1-DetentWidth){1'b0}}, detent};
      neg_lim = -lim;

      prev_ab_in  = prev_ab_ff;
      step_sum_in = step_sum_ff;
      dir_upd     = dir_ff;
      if (ctrl.pin_evt) begin
         prev_ab_in = {a_level, b_level};
         if (step != DIR_NONE) begin
            if (sum_ext >= lim) begin
               dir_upd     = DIR_CW;
               step_sum_in = '0;
            end else if (sum_ext <= neg_lim) begin
               dir_upd     = DIR_CCW;
               step_sum_in = '0;
            end else begin
               step_sum_in = sum_ext[SumWidth-1:0];
            end
         end
      end
      dir_in = ctrl.clr_dir ? DIR_NONE : dir_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff  <= 2'b11;
         step_sum_ff <= '0;
         dir_ff      <= DIR_NONE;
      end else begin
         prev_ab_ff  <= prev_ab_in;
         step_sum_ff <= step_sum_in;
         dir_ff      <= dir_in;
      end
   end

   a_clear_dir: assert property (@(posedge clock) disable iff (reset)
      ctrl.clr_dir |=> dir_ff == DIR_NONE)
      else $error("pending direction survived a read");

   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      !ctrl.pin_evt |=> $stable(prev_ab_ff) && $stable(step_sum_ff))
      else $error("decoder state moved without a pin event");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.pin_evt && step != DIR_NONE && sum_ext >= lim |=> step_sum_ff == '0)
      else $error("step sum not cleared at a detent");

endmodule

`default_nettype wire

FILE: sv/rotary_encoder_with_button_top.sv
// Top level of the rotary encoder and push button event block.
//
// Usage: every request transaction on req_bus carries one event: a pin change
// (new A/B levels), a button falling edge (switch level and millisecond time),
// a read-and-clear of the pending direction, or a read-and-clear of the pending
// press. Every request produces exactly one response transaction on rsp_bus with
// the pending direction (+1, -1 or 0) and press flag as they stand after the
// event's update and before its clear.
// The response is registered at the edge that accepts the request. Throughput is
// one transaction per cycle while rsp_bus is not stalled, set by the single response
// register; the state update is short logic in front of it.
// When the receiver stalls, the response register holds its transaction and
// req_bus.ready drops until it is taken; no request is lost.
// Reset (synchronous, active high) clears all pending flags, sets the previous
// pin pair to both-high, clears the step sum and press time, and loads the
// control registers with 4 detent steps and 250 ms debounce.
// The csr_ port writes detent_steps (index 0) and debounce_ms (index 1);
// write it only while the block is idle.
`default_nettype none

module rotary_encoder_with_button_top (
   input  wire                                      clock,
   input  wire                                      reset,
   reb_req_if.sink                                  req_bus,
   reb_rsp_if.source                                rsp_bus,
   input  wire                                      csr_we,
   input  wire reb_pkg::csr_index_type              csr_index,
   input  wire logic [reb_pkg::DebounceWidth-1:0]   csr_wdata
);
   import reb_pkg::*;

   // Control registers.
   logic [DetentWidth-1:0]   detent_ff, detent_in;
   logic [DebounceWidth-1:0] debounce_ff, debounce_in;

   // Button state.
   logic                     press_ff, press_in, press_upd;
   logic [TimeWidth-1:0]     last_press_ff, last_press_in;
   logic [TimeWidth-1:0]     elapsed;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   dir_type                  rsp_dir_ff;
   logic                     rsp_press_ff;

   logic                     req_fire;
   quad_ctrl_type            quad_ctrl;
   dir_type                  dir_upd;

   // A new transaction is taken whenever the response register is empty or
   // being emptied in this cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign quad_ctrl.pin_evt = req_fire && (req_bus.mode == MODE_PIN);
   assign quad_ctrl.clr_dir = req_fire && (req_bus.mode == MODE_READ_DIR);

   reb_quad u_quad (
      .clock   (clock),
      .reset   (reset),
      .detent  (detent_ff),
      .ctrl    (quad_ctrl),
      .a_level (req_bus.a_level),
      .b_level (req_bus.b_level),
      .dir_upd (dir_upd)
   );

   // Configuration writes.
   always_comb begin
      detent_in   = detent_ff;
      debounce_in = debounce_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DETENT_STEPS: detent_in   = csr_wdata[DetentWidth-1:0];
            CSR_DEBOUNCE_MS:  debounce_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   // Button debounce: the elapsed time wraps modulo 2^32. A passing edge always
   // stores its time, but latches a press only when the switch reads low.
   always_comb begin
      elapsed       = req_bus.now_ms - last_press_ff;
      press_upd     = press_ff;
      last_press_in = last_press_ff;
      if (req_fire && (req_bus.mode == MODE_BUTTON) &&
          (elapsed >= {{(TimeWidth-DebounceWidth){1'b0}}, debounce_ff})) begin
         last_press_in = req_bus.now_ms;
         if (!req_bus.sw_level) begin
            press_upd = 1'b1;
         end
      end
      press_in = (req_fire && (req_bus.mode == MODE_READ_PRESS)) ? 1'b0 : press_upd;
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         detent_ff     <= DETENT_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
         press_ff      <= 1'b0;
         last_press_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         detent_ff     <= detent_in;
         debounce_ff   <= debounce_in;
         press_ff      <= press_in;
         last_press_ff <= last_press_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // The response payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_dir_ff   <= dir_upd;
         rsp_press_ff <= press_upd;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.direction = rsp_dir_ff;
   assign rsp_bus.pressed   = rsp_press_ff;

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while the response register is full");

   a_press_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.mode == MODE_READ_PRESS |=> !press_ff && rsp_valid_ff)
      else $error("press flag not cleared by a read");

   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_bus.mode == MODE_BUTTON) |=> $stable(last_press_ff))
      else $error("press time changed without a button transaction");

   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no response");

endmodule

`default_nettype wire
